// File: hw/rtl/pcpf_pkg.sv
// pcpf_pkg: shared constants and types of the pitch comb postfilter
// register field widths, register index codes and the window reload states
// no dependencies

package pcpf_pkg;

	localparam int PERIOD_W   = 10;
	localparam int GAIN_W     = 16;
	localparam int GAIN_FRAC  = 15;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 2;

	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 10'd15;

	typedef logic signed [GAIN_W-1:0] gain_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_PERIOD,
		REG_GAIN_CENTER,
		REG_GAIN_INNER,
		REG_GAIN_OUTER
	} cfg_reg_t;

	// window reload: one history read per tap, newest tap last
	typedef enum logic [2:0] {
		RL_IDLE,
		RL_TAP_P1,
		RL_TAP_0,
		RL_TAP_M1,
		RL_TAP_M2
	} rl_state_t;

endpackage

// File: hw/rtl/pcpf_if.sv
// pcpf_if: valid/ready stream channels of the pitch comb postfilter
// pcpf_in_if carries input samples, pcpf_out_if carries filtered samples
// no dependencies

interface pcpf_in_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_in;
	logic                           frame_end;

	modport source (output valid, output sample_in, output frame_end, input ready);
	modport sink   (input valid, input sample_in, input frame_end, output ready);
endinterface

interface pcpf_out_if #(
	parameter int SAMPLE_WIDTH = 24
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] sample_out;
	logic                           frame_last;

	modport source (output valid, output sample_out, output frame_last, input ready);
	modport sink   (input valid, input sample_out, input frame_last, output ready);
endinterface

// File: hw/rtl/pcpf_hist.sv
// pcpf_hist: output history memory, one write and one registered read per cycle
// a fill count stands in for the clear after reset: unwritten entries read as zero
// depends on nothing; instantiated by pitch_comb_postfilter

module pcpf_hist #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data
);

	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_q;
	logic             rd_ok_q;
	logic [CW-1:0]    fill_q;
	logic             full;

	assign full = (fill_q == CW'(DEPTH));

	// writes run in address order from zero, so entry a is written once a < fill
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q  <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= full || (CW'(rd_addr) < fill_q);
			if (wr_en && !full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	assign rd_data = rd_ok_q ? rd_q : '0;

	a_write_in_order: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !full |-> CW'(wr_addr) == fill_q)
		else $error("history write out of fill order");

	a_fill_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> fill_q >= $past(fill_q))
		else $error("history fill count went back");

	a_same_edge_unwritten: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !full && rd_addr == wr_addr |=> !rd_ok_q)
		else $error("read of entry written at the same edge marked valid");

endmodule

// File: hw/rtl/pitch_comb_postfilter.sv
// pitch_comb_postfilter: five-tap pitch comb postfilter, one sample per item
// uses pcpf_pkg, the pcpf_in_if / pcpf_out_if channels and pcpf_hist
//
// channel    role   handshake    payload
// sample_ch  sink   valid/ready  sample_in[SAMPLE_WIDTH], frame_end
// result_ch  source valid/ready  sample_out[SAMPLE_WIDTH], frame_last
// cfg        write  cfg_we       cfg_index[2], cfg_wdata[16]
//
// one item per cycle unless stalled; each item passes stage one, the multiply
// stage and the output register; an item whose newest tap is the sample right
// before it (period 3 modulo the history depth) waits in stage one until that
// sample reaches the output register; the first item after reset or a frame end
// waits until the multiply stage is empty and then while four window taps and
// the newest tap go through the single history read port one at a time
// a pitch_period write holds the input while period mod depth settles
// no clearing pass after reset: a fill count makes unwritten history read as zero
// a stalled result holds in the output register; items keep entering until
// the three stages are full

module pitch_comb_postfilter
	import pcpf_pkg::*;
#(
	parameter int HISTORY_DEPTH = 1024,
	parameter int SAMPLE_WIDTH  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pcpf_in_if.sink               sample_ch,
	pcpf_out_if.source            result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam int AW     = $clog2(HISTORY_DEPTH);
	localparam int SW     = SAMPLE_WIDTH;
	localparam int PW     = PERIOD_W;
	localparam int RSHIFT = PW + AW;
	localparam int RECIP  = ((1 << RSHIFT) + HISTORY_DEPTH - 1) / HISTORY_DEPTH;
	localparam int MW     = $clog2(RECIP + 1);
	localparam int QW     = $clog2(((1 << PW) - 1) / HISTORY_DEPTH + 2);
	localparam int RW     = (PW > AW) ? PW : AW;
	localparam int AC     = SW + 19;
	localparam int YW     = AC - GAIN_FRAC;

	localparam logic [AW-1:0]        PER_MOD_RESET = AW'(PERIOD_RESET % HISTORY_DEPTH);
	localparam logic [QW-1:0]        QUOT_RESET    = QW'(PERIOD_RESET / HISTORY_DEPTH);
	localparam logic signed [AW+1:0] DEPTH_S       = (AW+2)'(HISTORY_DEPTH);
	localparam logic signed [AW+1:0] K_P2          = 2;
	localparam logic signed [AW+1:0] K_P1          = 1;
	localparam logic signed [AW+1:0] K_0           = 0;
	localparam logic signed [AW+1:0] K_M1          = -1;
	localparam logic signed [AW+1:0] K_M2          = -2;
	localparam logic signed [AC-1:0] RND           = AC'(1) <<< (GAIN_FRAC - 1);
	localparam logic signed [YW-1:0] YMAX          = YW'((64'sd1 <<< (SW - 1)) - 64'sd1);
	localparam logic signed [YW-1:0] YMIN          = -YMAX - YW'(1);

	// a + d modulo the depth, for |d| below the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
		input logic signed [AW+1:0] d);
		logic signed [AW+1:0] s;
		s = $signed({2'b00, a}) + d;
		if (s < 0) begin
			s = s + DEPTH_S;
		end else if (s >= DEPTH_S) begin
			s = s - DEPTH_S;
		end
		return s[AW-1:0];
	endfunction

	// configuration
	logic [PW-1:0] period_q;
	logic [QW-1:0] quot_q;
	logic [AW-1:0] per_mod_q;
	logic          mod_pend_q;
	gain_t         gc_q;
	gain_t         gi_q;
	gain_t         go_q;

	logic [PW+MW-1:0] recip_prod;
	logic [RW-1:0]    rem;

	assign recip_prod = (PW+MW)'(cfg_wdata[PW-1:0]) * (PW+MW)'(RECIP);
	assign rem        = RW'(period_q) - RW'(quot_q * HISTORY_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q   <= PERIOD_RESET;
			quot_q     <= QUOT_RESET;
			per_mod_q  <= PER_MOD_RESET;
			mod_pend_q <= 1'b0;
			gc_q       <= '0;
			gi_q       <= '0;
			go_q       <= '0;
		end else begin
			mod_pend_q <= 1'b0;
			if (mod_pend_q) begin
				per_mod_q <= AW'(rem);
			end
			if (cfg_we) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_PITCH_PERIOD: begin
						period_q   <= cfg_wdata[PW-1:0];
						quot_q     <= QW'(recip_prod >> RSHIFT);
						mod_pend_q <= 1'b1;
					end
					REG_GAIN_CENTER: gc_q <= gain_t'(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_INNER:  gi_q <= gain_t'(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_OUTER:  go_q <= gain_t'(cfg_wdata[GAIN_W-1:0]);
					default: ;
				endcase
			end
		end
	end

	// pipeline control
	logic          v_s1, v_s2, v_s3;
	logic          rl_s1;
	logic          en1, en2, en3;
	logic          go1, go2;
	logic          haz;
	logic          acc_in;
	logic          pending_q;
	logic [AW-1:0] wp_q;

	logic signed [SW-1:0] x_s1, x_s2;
	logic                 fe_s1, fe_s2, fe_s3;
	logic [AW-1:0]        wa_s1, wa_s2, wa_s3;
	logic [AW-1:0]        base_s1;
	logic [AW-1:0]        naddr_s1;
	logic signed [SW+15:0] pc_s2;
	logic signed [SW+16:0] pi_s2, po_s2;
	logic signed [SW-1:0] y_s3;

	logic [AW-1:0] base_in, naddr_in;
	logic [AW-1:0] rd_addr;
	logic [SW-1:0] rdata;

	rl_state_t            rl_state_q, rl_state_d;
	logic                 rl_issue;
	logic signed [AW+1:0] rl_off;
	logic                 win_load;
	logic [1:0]           win_idx;
	logic                 rl_done;

	assign base_in  = wrap_add(wp_q, -$signed({2'b00, per_mod_q}));
	assign naddr_in = wrap_add(base_in, K_P2);

	assign en3 = !v_s3 || result_ch.ready;
	assign en2 = !v_s2 || en3;
	// the newest tap may not be the sample still in the sum stage
	assign haz = v_s2 && (wa_s2 == naddr_s1);
	assign go1 = v_s1 && en2 && !rl_s1 && !haz;
	assign go2 = v_s2 && en3;
	assign en1 = !v_s1 || go1;

	assign sample_ch.ready = en1 && !mod_pend_q;
	assign acc_in          = sample_ch.valid && sample_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			rl_s1      <= 1'b0;
			pending_q  <= 1'b1;
			wp_q       <= '0;
			rl_state_q <= RL_IDLE;
		end else begin
			rl_state_q <= rl_state_d;
			if (acc_in) begin
				v_s1      <= 1'b1;
				rl_s1     <= pending_q;
				pending_q <= sample_ch.frame_end;
				wp_q      <= wrap_add(wp_q, K_P1);
			end else if (go1) begin
				v_s1 <= 1'b0;
			end else if (rl_done) begin
				rl_s1 <= 1'b0;
			end
			if (go1) begin
				v_s2 <= 1'b1;
			end else if (go2) begin
				v_s2 <= 1'b0;
			end
			if (go2) begin
				v_s3 <= 1'b1;
			end else if (result_ch.ready) begin
				v_s3 <= 1'b0;
			end
		end
	end

	// window reload sequencer
	always_comb begin
		rl_state_d = rl_state_q;
		unique case (rl_state_q)
			RL_IDLE: begin
				if (v_s1 && rl_s1 && !v_s2) begin
					rl_state_d = RL_TAP_P1;
				end
			end
			RL_TAP_P1: rl_state_d = RL_TAP_0;
			RL_TAP_0:  rl_state_d = RL_TAP_M1;
			RL_TAP_M1: rl_state_d = RL_TAP_M2;
			RL_TAP_M2: rl_state_d = RL_IDLE;
			default:   rl_state_d = RL_IDLE;
		endcase
	end

	always_comb begin
		rl_issue = 1'b0;
		rl_off   = K_0;
		win_load = 1'b0;
		win_idx  = 2'd0;
		rl_done  = 1'b0;
		unique case (rl_state_q)
			RL_IDLE: begin
				rl_issue = v_s1 && rl_s1 && !v_s2;
				rl_off   = K_P1;
			end
			RL_TAP_P1: begin
				win_load = 1'b1;
				win_idx  = 2'd0;
				rl_issue = 1'b1;
				rl_off   = K_0;
			end
			RL_TAP_0: begin
				win_load = 1'b1;
				win_idx  = 2'd1;
				rl_issue = 1'b1;
				rl_off   = K_M1;
			end
			RL_TAP_M1: begin
				win_load = 1'b1;
				win_idx  = 2'd2;
				rl_issue = 1'b1;
				rl_off   = K_M2;
			end
			RL_TAP_M2: begin
				// the held item re-reads its newest tap in this cycle
				win_load = 1'b1;
				win_idx  = 2'd3;
				rl_done  = 1'b1;
			end
			default: ;
		endcase
	end

	// a held item re-reads each cycle so its tap sees every finished write
	always_comb begin
		priority if (rl_issue) begin
			rd_addr = wrap_add(base_s1, rl_off);
		end else if (v_s1 && !go1) begin
			rd_addr = naddr_s1;
		end else begin
			rd_addr = naddr_in;
		end
	end

	logic signed [AC-1:0] acc;
	logic signed [YW-1:0] y_full;
	logic signed [SW-1:0] y;

	pcpf_hist #(
		.DEPTH (HISTORY_DEPTH),
		.WIDTH (SW)
	) u_hist (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_addr (rd_addr),
		.rd_data (rdata),
		.wr_en   (go2),
		.wr_addr (wa_s2),
		.wr_data (y)
	);

	// tap window and multiply stage
	logic signed [SW-1:0] win_q [4];
	logic signed [SW-1:0] nw;
	logic signed [SW:0]   sum_i, sum_o;

	// the output register holds a sample written at the edge of the last read
	assign nw    = (v_s3 && wa_s3 == naddr_s1) ? y_s3 : $signed(rdata);
	assign sum_i = (SW+1)'(win_q[0]) + (SW+1)'(win_q[2]);
	assign sum_o = (SW+1)'(nw) + (SW+1)'(win_q[3]);

	always_ff @(posedge clk) begin
		if (win_load) begin
			win_q[win_idx] <= $signed(rdata);
		end else if (go1) begin
			win_q[3] <= win_q[2];
			win_q[2] <= win_q[1];
			win_q[1] <= win_q[0];
			win_q[0] <= nw;
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			x_s1     <= sample_ch.sample_in;
			fe_s1    <= sample_ch.frame_end;
			wa_s1    <= wp_q;
			base_s1  <= base_in;
			naddr_s1 <= naddr_in;
		end
		if (go1) begin
			pc_s2 <= gc_q * win_q[1];
			pi_s2 <= gi_q * sum_i;
			po_s2 <= go_q * sum_o;
			x_s2  <= x_s1;
			fe_s2 <= fe_s1;
			wa_s2 <= wa_s1;
		end
		if (go2) begin
			y_s3  <= y;
			fe_s3 <= fe_s2;
			wa_s3 <= wa_s2;
		end
	end

	// sum, round half up, saturate
	assign acc    = (AC'(x_s2) <<< GAIN_FRAC) + AC'(pc_s2) + AC'(pi_s2) + AC'(po_s2) + RND;
	assign y_full = acc[AC-1:GAIN_FRAC];

	always_comb begin
		priority if (y_full > YMAX) begin
			y = YMAX[SW-1:0];
		end else if (y_full < YMIN) begin
			y = YMIN[SW-1:0];
		end else begin
			y = y_full[SW-1:0];
		end
	end

	assign result_ch.valid      = v_s3;
	assign result_ch.sample_out = y_s3;
	assign result_ch.frame_last = fe_s3;

	a_reload_drained: assert property (@(posedge clk) disable iff (!arst_n)
		rl_state_q != RL_IDLE |-> !v_s2)
		else $error("window reload while a write is still pending");

	a_reload_owner: assert property (@(posedge clk) disable iff (!arst_n)
		rl_state_q != RL_IDLE |-> v_s1 && rl_s1)
		else $error("window reload without a reloading item in stage one");

	a_item_order: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> wa_s1 == wrap_add(wa_s2, K_P1))
		else $error("history addresses of adjacent items out of order");

endmodule

// File: tb/pcpf_checker.sv
// pcpf_checker: scoreboard for the pitch comb postfilter
// follows register writes, predicts each filtered sample and checks results in order
// uses pcpf_pkg and the pcpf_in_if / pcpf_out_if channels

module pcpf_checker
	import pcpf_pkg::*;
#(
	parameter int HISTORY_DEPTH = 1024,
	parameter int SAMPLE_WIDTH  = 24
) (
	input  logic                  clk,
	input  logic                  arst_n,
	pcpf_in_if                    sample_ch,
	pcpf_out_if                   result_ch,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    pending,
	output int                    mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef struct packed {
		sample_t sample;
		logic    last;
	} filtered_t;

	localparam longint SAT_MAX = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint SAT_MIN = -SAT_MAX - 1;

	logic [PERIOD_W-1:0] period;
	gain_t               gain_c;
	gain_t               gain_i;
	gain_t               gain_o;
	sample_t             history [HISTORY_DEPTH];
	int                  wr_ptr;
	sample_t             window [4];   // [0] is y[n-T+1] down to [3] at y[n-T-2]
	logic                reload;
	filtered_t           filtered_q [$];
	int                  fail_cnt = 0;

	// history slot at write pointer - period + k, wrapping with no range check
	function automatic sample_t hist_tap(int k);
		return history[(wr_ptr + 2 * HISTORY_DEPTH - int'(period) % HISTORY_DEPTH + k)
			% HISTORY_DEPTH];
	endfunction

	function automatic filtered_t comb_filter(sample_t x, logic fe);
		sample_t   newest;
		longint    acc;
		filtered_t res;
		if (reload) begin
			window[0] = hist_tap(1);
			window[1] = hist_tap(0);
			window[2] = hist_tap(-1);
			window[3] = hist_tap(-2);
			reload    = 1'b0;
		end
		newest = hist_tap(2);
		acc = longint'(x) * (longint'(1) <<< GAIN_FRAC)
			+ longint'(gain_c) * longint'(window[1])
			+ longint'(gain_i) * (longint'(window[0]) + longint'(window[2]))
			+ longint'(gain_o) * (longint'(newest) + longint'(window[3]));
		// round half up, then clamp to the sample range
		acc = (acc + (longint'(1) <<< (GAIN_FRAC - 1))) >>> GAIN_FRAC;
		if (acc > SAT_MAX) begin
			acc = SAT_MAX;
		end else if (acc < SAT_MIN) begin
			acc = SAT_MIN;
		end
		window[3] = window[2];
		window[2] = window[1];
		window[1] = window[0];
		window[0] = newest;
		res.sample = sample_t'(acc);
		res.last   = fe;
		history[wr_ptr] = res.sample;
		wr_ptr = (wr_ptr + 1) % HISTORY_DEPTH;
		reload = fe;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : scoreboard
		filtered_t want;
		if (!arst_n) begin
			period = PERIOD_RESET;
			gain_c = '0;
			gain_i = '0;
			gain_o = '0;
			for (int i = 0; i < HISTORY_DEPTH; i++) begin
				history[i] = '0;
			end
			for (int i = 0; i < 4; i++) begin
				window[i] = '0;
			end
			wr_ptr = 0;
			reload = 1'b1;
			filtered_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_PITCH_PERIOD: period = cfg_wdata[PERIOD_W-1:0];
					REG_GAIN_CENTER:  gain_c = gain_t'(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_INNER:   gain_i = gain_t'(cfg_wdata[GAIN_W-1:0]);
					REG_GAIN_OUTER:   gain_o = gain_t'(cfg_wdata[GAIN_W-1:0]);
					default: ;
				endcase
			end
			if (result_ch.valid && result_ch.ready) begin
				if (filtered_q.size() == 0) begin
					$display("%0t: result with none expected: sample_out %0d frame_last %0b",
						$time, result_ch.sample_out, result_ch.frame_last);
					fail_cnt++;
				end else begin
					want = filtered_q.pop_front();
					if (result_ch.sample_out !== want.sample) begin
						$display("%0t: sample_out expected %0d got %0d", $time,
							$signed(want.sample), result_ch.sample_out);
						fail_cnt++;
					end
					if (result_ch.frame_last !== want.last) begin
						$display("%0t: frame_last expected %0b got %0b", $time,
							want.last, result_ch.frame_last);
						fail_cnt++;
					end
				end
			end
			if (sample_ch.valid && sample_ch.ready) begin
				filtered_q.push_back(comb_filter(sample_ch.sample_in, sample_ch.frame_end));
			end
		end
		pending    <= filtered_q.size();
		mismatches <= fail_cnt;
	end

endmodule

// File: tb/tb.sv
// tb: top of the pitch comb postfilter testbench
// drives samples and register writes, stalls the result side and gives the verdict
// uses pcpf_pkg, the pcpf channels, pcpf_checker and pitch_comb_postfilter

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pcpf_pkg::*;

	localparam int HISTORY_DEPTH = 1024;
	localparam int SAMPLE_WIDTH  = 24;
	localparam int ITEM_TARGET   = 1850;
	localparam int HOLD_CYCLES   = 300;
	localparam int END_WAIT      = 16;
	localparam int LIMIT_CYCLES  = 500_000;

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
	typedef enum {RX_STREAM, RX_MOSTLY, RX_SPARSE, RX_EVERY_THIRD} rx_mode_t;

	localparam sample_t SMAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam sample_t SMIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
	localparam gain_t   GMAX = {1'b0, {(GAIN_W-1){1'b1}}};
	localparam gain_t   GMIN = {1'b1, {(GAIN_W-1){1'b0}}};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	logic                  hold_req;
	int                    pending;
	int                    mismatches;
	int                    cycles = 0;
	int                    items_sent = 0;
	int                    burst_left = 0;
	int                    frame_left = 0;

	pcpf_in_if  #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) sample_ch ();
	pcpf_out_if #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) result_ch ();

	pitch_comb_postfilter #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.sample_ch(sample_ch),
		.result_ch(result_ch),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	pcpf_checker #(
		.HISTORY_DEPTH(HISTORY_DEPTH),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) i_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.pending   (pending),
		.mismatches(mismatches)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("** pitch_comb_postfilter: FAILED **");
			$finish;
		end
	end

	function automatic gain_t pick_gain();
		case ($urandom_range(0, 7))
			0:       return GMAX;
			1:       return GMIN;
			2:       return '0;
			3:       return gain_t'($urandom);
			default: return gain_t'(int'($urandom_range(0, 16383)) - 8192);
		endcase
	endfunction

	function automatic sample_t pick_sample();
		case ($urandom_range(0, 9))
			0:       return SMAX;
			1:       return SMIN;
			2, 3:    return sample_t'($urandom);
			default: return sample_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
		endcase
	endfunction

	// frames of random length, now and then a single-sample frame
	function automatic logic next_frame_end();
		if (frame_left == 0) begin
			case ($urandom_range(0, 9))
				0:          frame_left = 1;
				1, 2, 3, 4: frame_left = $urandom_range(2, 16);
				default:    frame_left = $urandom_range(17, 240);
			endcase
		end
		frame_left--;
		return frame_left == 0;
	endfunction

	task automatic offer(sample_t s, logic fe);
		sample_ch.valid     <= 1'b1;
		sample_ch.sample_in <= s;
		sample_ch.frame_end <= fe;
		do @(posedge clk); while (!sample_ch.ready);
		items_sent++;
	endtask

	task automatic send_item(sample_t s, logic fe);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
			if (gap != 0) begin
				sample_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 30);
		end
		burst_left--;
		offer(s, fe);
	endtask

	// the first edge lets the checker count the last item sent
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic load_settings(logic [PERIOD_W-1:0] per, gain_t gc, gain_t gi, gain_t go);
		logic [CFG_DATA_W-PERIOD_W-1:0] junk;
		junk = $urandom;
		drain();
		cfg_we    <= 1'b1;
		cfg_index <= REG_PITCH_PERIOD;
		cfg_wdata <= {junk, per};   // bits above the period field are don't care
		@(posedge clk);
		cfg_index <= REG_GAIN_CENTER;
		cfg_wdata <= gc;
		@(posedge clk);
		cfg_index <= REG_GAIN_INNER;
		cfg_wdata <= gi;
		@(posedge clk);
		cfg_index <= REG_GAIN_OUTER;
		cfg_wdata <= go;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin : receiver
		rx_mode_t mode;
		int       left;
		bit       held;
		mode = RX_STREAM;
		left = 0;
		held = 1'b0;
		result_ch.ready <= 1'b0;
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				if (!hold_req) begin
					held = 1'b0;
				end
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(8, 120);
				end
				left--;
				case (mode)
					RX_STREAM:  result_ch.ready <= 1'b1;
					RX_MOSTLY:  result_ch.ready <= ($urandom_range(0, 3) != 0);
					RX_SPARSE:  result_ch.ready <= ($urandom_range(0, 3) == 0);
					default:    result_ch.ready <= (left % 3 == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin : stimulus
		int                  phase_no;
		int                  n;
		logic [PERIOD_W-1:0] per;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_index           <= REG_PITCH_PERIOD;
		cfg_wdata           <= '0;
		hold_req            <= 1'b0;
		sample_ch.valid     <= 1'b0;
		sample_ch.sample_in <= '0;
		sample_ch.frame_end <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: all gains zero, so samples pass straight through
		send_item(SMAX, 1'b0);
		send_item(SMIN, 1'b0);
		send_item('0, 1'b1);
		send_item(sample_t'(-1), 1'b0);
		send_item(sample_t'(1), 1'b0);
		send_item(sample_t'(24'h555555), 1'b1);

		// shortest legal period with full-scale gains, drives saturation
		load_settings(PERIOD_W'(3), GMAX, GMIN, GMAX);
		send_item(SMAX, 1'b0);
		send_item(SMAX, 1'b0);
		send_item(SMIN, 1'b0);
		send_item(SMAX, 1'b1);
		send_item(SMIN, 1'b0);
		send_item('0, 1'b0);

		// period drops below the legal range in the middle of a frame
		load_settings(PERIOD_W'(1), GMIN, GMAX, GMIN);
		send_item(SMIN, 1'b0);
		send_item(SMAX, 1'b0);
		send_item(sample_t'(12345), 1'b1);
		send_item(sample_t'(-4000000), 1'b0);

		// longest period, one below the store depth, taps wrap
		load_settings(PERIOD_W'(1023), gain_t'(16384), gain_t'(8192), gain_t'(-8192));
		send_item(SMAX, 1'b1);
		send_item(SMIN, 1'b0);
		send_item(sample_t'(1), 1'b0);

		load_settings(PERIOD_W'(0), GMAX, '0, '0);
		send_item(sample_t'(-1), 1'b1);
		send_item(SMAX, 1'b0);
		send_item(sample_t'(2), 1'b0);

		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			case ($urandom_range(0, 9))
				0:       per = PERIOD_W'($urandom_range(0, 2));
				1:       per = PERIOD_W'($urandom_range(1022, 1023));
				2:       per = PERIOD_W'(3);
				3, 4:    per = PERIOD_W'($urandom_range(3, 1021));
				default: per = PERIOD_W'($urandom_range(4, 48));
			endcase
			load_settings(per, pick_gain(), pick_gain(), pick_gain());
			if (phase_no == 2) begin
				// result side holds off while samples keep coming
				hold_req <= 1'b1;
				repeat (48) offer(pick_sample(), next_frame_end());
				hold_req <= 1'b0;
			end
			n = $urandom_range(40, 160);
			repeat (n) send_item(pick_sample(), next_frame_end());
			phase_no++;
		end

		drain();
		repeat (END_WAIT) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("** pitch_comb_postfilter: PASSED **");
		end else begin
			$display("** pitch_comb_postfilter: FAILED **");
		end
		$finish;
	end

endmodule
